@@ design/mnsl_pkg.sv @@
package mnsl_pkg;

    localparam int MAX_SEEDS = 64;
    localparam int MAP_SIDE  = 1024;
    localparam int IDX_W     = $clog2(MAX_SEEDS);
    localparam int COORD_W   = 10;
    localparam int DIST_W    = COORD_W + 1;
    localparam int COUNT_W   = 7;

    localparam logic [COORD_W-1:0] MAP_MAX   = COORD_W'(MAP_SIDE - 1);
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Query request travelling down the cell chain with its running best match.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        logic [IDX_W-1:0]   best_idx;
        logic [DIST_W-1:0]  best_d;
    } t_token;

    // Seed write broadcast to every cell.
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_seed_wr;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] c;
        c = (v > MAP_MAX) ? MAP_MAX : v;
        return c;
    endfunction

endpackage

@@ design/mnsl_if.sv @@
interface mnsl_in_if
    import mnsl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [IDX_W-1:0]   seed_index;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;

    modport source (output valid, kind, seed_index, pos_x, pos_y, input ready);
    modport sink   (input valid, kind, seed_index, pos_x, pos_y, output ready);
endinterface

interface mnsl_out_if
    import mnsl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  nearest_seed;
    logic [DIST_W-1:0] nearest_distance;

    modport source (output valid, nearest_seed, nearest_distance, input ready);
    modport sink   (input valid, nearest_seed, nearest_distance, output ready);
endinterface

@@ design/mnsl_cell.sv @@
module mnsl_cell
    import mnsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  logic             i_active,
    input  logic             i_first,
    input  t_seed_wr         i_wr,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic [COORD_W-1:0] r_sx;
    logic [COORD_W-1:0] r_sy;
    logic               r_valid;
    t_token             r_tok;
    t_token             n_tok;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [DIST_W-1:0]  d;

    // Seed point held by this cell; only the cell whose slot matches takes it.
    always_ff @(posedge i_clk) begin
        if (i_wr.we && (i_wr.idx == i_cell_idx)) begin
            r_sx <= i_wr.x;
            r_sy <= i_wr.y;
        end
    end

    always_comb begin
        dx = (i_tok.qx >= r_sx) ? (i_tok.qx - r_sx) : (r_sx - i_tok.qx);
        dy = (i_tok.qy >= r_sy) ? (i_tok.qy - r_sy) : (r_sy - i_tok.qy);
        d  = {1'b0, dx} + {1'b0, dy};
        n_tok = i_tok;
        // Strictly smaller replaces, so a tie keeps the lower index.
        if (i_tok.valid && i_active && (i_first || (d < i_tok.best_d))) begin
            n_tok.best_idx = i_cell_idx;
            n_tok.best_d   = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_valid;
    end

endmodule

@@ design/manhattan_nearest_seed_labeler_top.sv @@
// Nearest-seed labeler under the Manhattan metric. A load request (kind 0)
// writes one seed point into slot seed_index; it gives no result. A query
// request (kind 1) travels down a chain of MAX_SEEDS cells, one cell per
// cycle, each cell holding one seed and comparing it with the running best.
// The result then moves into the output register, and the next request is
// accepted from the cycle in which it appears; no request is accepted while
// a query is in flight. Seeds at or above seed_count are skipped; seed 0
// always takes part, and ties go to the lower index. seed_count resets to 1
// and is written through i_cfg_we / i_cfg_data; the user must write it only
// while no query is in flight, as the block does not enforce this. A slot
// must be loaded before a query reads it.
module manhattan_nearest_seed_labeler_top
    import mnsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    mnsl_in_if.sink            i_in,
    mnsl_out_if.source         o_out
);

    logic [COUNT_W-1:0] r_seed_count;
    logic               r_busy;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_seed;
    logic [DIST_W-1:0]  r_out_dist;

    t_token             tok [0:MAX_SEEDS];
    t_seed_wr           seed_wr;
    logic [MAX_SEEDS-1:0] tok_valid;
    logic               in_acc;
    logic               en;
    logic               tail_take;
    t_token             tail;

    assign tail   = tok[MAX_SEEDS];
    assign in_acc = i_in.valid && i_in.ready;

    // The chain only holds one query at a time, so a single enable is enough.
    // It stops when the finished query cannot move into a full output register.
    assign en        = !(tail.valid && r_out_valid && !o_out.ready);
    assign tail_take = tail.valid && (!r_out_valid || o_out.ready);

    assign i_in.ready = !r_busy;

    always_comb begin
        seed_wr.we  = in_acc && (i_in.kind == KIND_LOAD);
        seed_wr.idx = i_in.seed_index;
        seed_wr.x   = clamp_coord(i_in.pos_x);
        seed_wr.y   = clamp_coord(i_in.pos_y);
    end

    // Head of the chain: a fresh query with no best match yet.
    always_comb begin
        tok[0].valid    = in_acc && (i_in.kind == KIND_QUERY);
        tok[0].qx       = clamp_coord(i_in.pos_x);
        tok[0].qy       = clamp_coord(i_in.pos_y);
        tok[0].best_idx = '0;
        tok[0].best_d   = '0;
    end

    for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
        logic active;
        // A count above the table depth simply enables every cell.
        assign active = (g == 0) || (COUNT_W'(g) < r_seed_count);
        assign tok_valid[g] = tok[g+1].valid;

        mnsl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_cell_idx (IDX_W'(g)),
            .i_active   (active),
            .i_first    (g == 0),
            .i_wr       (seed_wr),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            r_seed_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && (i_in.kind == KIND_QUERY)) begin
                r_busy <= 1'b1;
            end else if (tail_take) begin
                r_busy <= 1'b0;
            end
            if (tail_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_take) begin
            r_out_seed <= tail.best_idx;
            r_out_dist <= tail.best_d;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.nearest_seed     = r_out_seed;
    assign o_out.nearest_distance = r_out_dist;

    // At most one query is ever in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one query in the cell chain");

    // A query in the chain always keeps the block busy.
    a_busy_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_valid != '0) |-> r_busy)
        else $error("query in flight while block reports idle");

    // An accepted query enters the first cell on the next edge.
    a_query_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.kind == KIND_QUERY)) |=> tok_valid[0])
        else $error("accepted query did not enter the chain");

    // Loads never start a scan.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.kind == KIND_LOAD)) |=> !r_busy)
        else $error("load request made the block busy");

endmodule
